### rtl/uvlt_pkg.sv
// package: request and result types, operation and status codes, control types
`timescale 1ns / 1ps

package uvlt_pkg;

  // operation codes
  localparam logic [2:0] FUNC_CLEAR  = 3'd0;
  localparam logic [2:0] FUNC_COUNT  = 3'd1;
  localparam logic [2:0] FUNC_SEARCH = 3'd2;
  localparam logic [2:0] FUNC_INSERT = 3'd3;
  localparam logic [2:0] FUNC_DELETE = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // request payload
  typedef struct packed {
    logic        [2:0]  func;
    logic signed [31:0] value;
  } req_t;

  // result payload
  typedef struct packed {
    logic [1:0] status;
    logic [5:0] position;
    logic [6:0] count;
  } rsp_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  // source of the reported position
  typedef enum logic [1:0] {
    POS_ZERO,
    POS_MATCH,
    POS_SAVED,
    POS_TAIL
  } pos_sel_t;

  // change to the entry count at finish
  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_CLEAR,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load;
    logic       scan;
    logic       shift_init;
    logic       shift;
    logic       finish;
    logic       append;
    logic [1:0] status;
    pos_sel_t   pos_sel;
    cnt_op_t    cnt_op;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] func;
    logic       hit;
    logic       miss;
    logic       full;
    logic       shift_done;
  } dp_stat_t;

endpackage

### rtl/uvlt_ctrl.sv
// controller: sequences scan, shift and finish of each request
`timescale 1ns / 1ps

module uvlt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2:0]          req_func,
  input  uvlt_pkg::dp_stat_t  stat,
  output logic                busy,
  output uvlt_pkg::cmd_t      cmd
);

  uvlt_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= uvlt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      uvlt_pkg::S_IDLE: begin
        if (start) begin
          case (req_func)
            uvlt_pkg::FUNC_SEARCH,
            uvlt_pkg::FUNC_INSERT,
            uvlt_pkg::FUNC_DELETE: state_next = uvlt_pkg::S_SCAN;
            default:               state_next = uvlt_pkg::S_IDLE;
          endcase
        end
      end
      uvlt_pkg::S_SCAN: begin
        if (stat.hit && stat.func == uvlt_pkg::FUNC_DELETE) begin
          state_next = uvlt_pkg::S_SHIFT;
        end else if (stat.hit || stat.miss) begin
          state_next = uvlt_pkg::S_IDLE;
        end
      end
      uvlt_pkg::S_SHIFT: begin
        if (stat.shift_done) begin
          state_next = uvlt_pkg::S_IDLE;
        end
      end
      default: state_next = uvlt_pkg::S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd = '0;
    cmd.status  = uvlt_pkg::ST_OK;
    cmd.pos_sel = uvlt_pkg::POS_ZERO;
    cmd.cnt_op  = uvlt_pkg::CNT_KEEP;
    case (state)
      uvlt_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (req_func)
            uvlt_pkg::FUNC_CLEAR: begin
              cmd.finish = 1'b1;
              cmd.cnt_op = uvlt_pkg::CNT_CLEAR;
            end
            uvlt_pkg::FUNC_SEARCH,
            uvlt_pkg::FUNC_INSERT,
            uvlt_pkg::FUNC_DELETE: cmd.finish = 1'b0;
            default:               cmd.finish = 1'b1;
          endcase
        end
      end
      uvlt_pkg::S_SCAN: begin
        cmd.scan = !stat.hit && !stat.miss;
        case (stat.func)
          uvlt_pkg::FUNC_SEARCH: begin
            if (stat.hit) begin
              cmd.finish  = 1'b1;
              cmd.pos_sel = uvlt_pkg::POS_MATCH;
            end else if (stat.miss) begin
              cmd.finish = 1'b1;
              cmd.status = uvlt_pkg::ST_MISSING;
            end
          end
          uvlt_pkg::FUNC_INSERT: begin
            if (stat.hit) begin
              cmd.finish  = 1'b1;
              cmd.status  = uvlt_pkg::ST_PRESENT;
              cmd.pos_sel = uvlt_pkg::POS_MATCH;
            end else if (stat.miss && stat.full) begin
              cmd.finish = 1'b1;
              cmd.status = uvlt_pkg::ST_FULL;
            end else if (stat.miss) begin
              cmd.finish  = 1'b1;
              cmd.append  = 1'b1;
              cmd.pos_sel = uvlt_pkg::POS_TAIL;
              cmd.cnt_op  = uvlt_pkg::CNT_INC;
            end
          end
          uvlt_pkg::FUNC_DELETE: begin
            if (stat.hit) begin
              cmd.shift_init = 1'b1;
            end else if (stat.miss) begin
              cmd.finish = 1'b1;
              cmd.status = uvlt_pkg::ST_MISSING;
            end
          end
          default: cmd.finish = stat.hit || stat.miss;
        endcase
      end
      uvlt_pkg::S_SHIFT: begin
        if (stat.shift_done) begin
          cmd.finish  = 1'b1;
          cmd.pos_sel = uvlt_pkg::POS_SAVED;
          cmd.cnt_op  = uvlt_pkg::CNT_DEC;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      default: cmd.finish = 1'b0;
    endcase
  end

  assign busy = (state != uvlt_pkg::S_IDLE);

endmodule

### rtl/uvlt_datapath.sv
// datapath: value store, scan and shift pointer, entry count, result register
`timescale 1ns / 1ps

module uvlt_datapath #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  uvlt_pkg::req_t      req,
  input  uvlt_pkg::cmd_t      cmd,
  output uvlt_pkg::dp_stat_t  stat,
  output logic                done,
  output uvlt_pkg::rsp_t      rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // value store, one write and one registered read per cycle
  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rdata;

  logic [2:0]    func_q;
  logic [31:0]   value_q;
  logic [CW-1:0] ptr;
  logic          pend;
  logic [IW-1:0] tag_idx;
  logic [IW-1:0] pos_q;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  logic          in_range;
  logic          rd_en;
  logic          match;
  logic [IW-1:0] pos_mux;

  assign in_range = (ptr < count);
  assign rd_en    = (cmd.scan || cmd.shift) && in_range;
  assign match    = pend && (rdata == value_q);

  // status toward the controller
  always_comb begin
    stat.func       = func_q;
    stat.hit        = match;
    stat.miss       = !match && !in_range;
    stat.full       = (count >= CW'(CAPACITY));
    stat.shift_done = !in_range && !pend;
  end

  // store read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[ptr[IW-1:0]];
    end
  end

  // store write: move an entry down during a delete, or append at the tail
  always_ff @(posedge clk) begin
    if (cmd.shift && pend) begin
      mem[tag_idx] <= rdata;
    end else if (cmd.append) begin
      mem[count[IW-1:0]] <= value_q;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= req.func;
      value_q <= req.value;
    end
    if (cmd.shift_init) begin
      pos_q <= tag_idx;
    end
  end

  // scan and shift pointer; tag_idx is the compared index or the write index
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr     <= '0;
      pend    <= 1'b0;
      tag_idx <= '0;
    end else if (cmd.load) begin
      ptr  <= '0;
      pend <= 1'b0;
    end else if (cmd.shift_init) begin
      ptr  <= CW'(tag_idx) + CW'(1);
      pend <= 1'b0;
    end else if (cmd.scan) begin
      pend    <= in_range;
      tag_idx <= ptr[IW-1:0];
      if (in_range) begin
        ptr <= ptr + CW'(1);
      end
    end else if (cmd.shift) begin
      pend <= in_range;
      if (in_range) begin
        tag_idx <= IW'(ptr - CW'(1));
        ptr     <= ptr + CW'(1);
      end
    end
  end

  // count update
  always_comb begin
    count_next = count;
    case (cmd.cnt_op)
      uvlt_pkg::CNT_KEEP:  count_next = count;
      uvlt_pkg::CNT_CLEAR: count_next = '0;
      uvlt_pkg::CNT_INC:   count_next = count + CW'(1);
      uvlt_pkg::CNT_DEC:   count_next = count - CW'(1);
      default:             count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.finish) begin
      count <= count_next;
    end
  end

  // reported position
  always_comb begin
    pos_mux = '0;
    case (cmd.pos_sel)
      uvlt_pkg::POS_ZERO:  pos_mux = '0;
      uvlt_pkg::POS_MATCH: pos_mux = tag_idx;
      uvlt_pkg::POS_SAVED: pos_mux = pos_q;
      uvlt_pkg::POS_TAIL:  pos_mux = count[IW-1:0];
      default:             pos_mux = '0;
    endcase
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.status   <= cmd.status;
      rsp.position <= 6'(pos_mux);
      rsp.count    <= 7'(count_next);
    end
  end

endmodule

### rtl/unique_value_list_table_unit.sv
// top level: unique value list with insert, search and order-keeping delete
//
// A request (func, value) is taken at a clock edge where start is high and
// busy is low. Each request gives exactly one result (status, position,
// count), shown on rsp for one cycle while done is high; the receiver
// cannot hold it off, so it must take the result in that cycle.
// Clear, count and unused codes: done rises the cycle after the request,
// and a new request may follow in the next cycle.
// Search and insert scan the held entries in order, one entry per cycle
// through the store's registered read port, and stop early on a hit.
// Delete scans to the hit at index k and then moves each later entry down
// one place, one per cycle on the same read port.
// The single read port of the value store sets this pace.
// busy is high from the cycle after a scanning request until its result.
// Reset empties the list and drops any request in flight; the store needs
// no clearing, as only entries below the count are ever read.
`timescale 1ns / 1ps

module unique_value_list_table_unit #(
  parameter int CAPACITY = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  uvlt_pkg::req_t  req,
  output logic            done,
  output uvlt_pkg::rsp_t  rsp
);

  uvlt_pkg::cmd_t     cmd;
  uvlt_pkg::dp_stat_t stat;

  // control sequencer
  uvlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_func (req.func),
    .stat     (stat),
    .busy     (busy),
    .cmd      (cmd)
  );

  // store and result datapath
  uvlt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .done (done),
    .rsp  (rsp)
  );

endmodule

### test/tb_unique_value_list_table_unit.sv
// testbench: unique value list unit against an in-bench list predictor
`timescale 1ns / 1ps

module tb_unique_value_list_table_unit;

  localparam int CAPACITY = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
  localparam int MAX_GAP = 6;
  localparam logic [2:0] FUNC_LAST = 3'd7;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic done;
  uvlt_pkg::req_t req;
  uvlt_pkg::rsp_t rsp;

  // predicted list contents and results still owed by the block
  logic [31:0]    list_vals [CAPACITY];
  int             list_len;
  uvlt_pkg::rsp_t pending_rsp [$];
  uvlt_pkg::rsp_t owed;
  logic [31:0]    value_pool [$];
  bit             no_gaps;
  int             errors;
  int             cycles = 0;

  unique_value_list_table_unit #(.CAPACITY(CAPACITY)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // index of a held value, or list_len when it is not held
  function automatic int find_pos(logic [31:0] v);
    for (int i = 0; i < list_len; i++)
      if (list_vals[i] == v) return i;
    return list_len;
  endfunction

  // apply one request to the predicted list and return the result it gives
  function automatic uvlt_pkg::rsp_t list_update(uvlt_pkg::req_t r);
    uvlt_pkg::rsp_t e;
    int             idx;
    e = '0;
    e.status = uvlt_pkg::ST_OK;
    idx = find_pos(r.value);
    case (r.func)
      uvlt_pkg::FUNC_CLEAR: list_len = 0;
      uvlt_pkg::FUNC_SEARCH: begin
        if (idx < list_len) e.position = idx[5:0];
        else e.status = uvlt_pkg::ST_MISSING;
      end
      uvlt_pkg::FUNC_INSERT: begin
        if (idx < list_len) begin
          e.status = uvlt_pkg::ST_PRESENT;
          e.position = idx[5:0];
        end else if (list_len >= CAPACITY) begin
          e.status = uvlt_pkg::ST_FULL;
        end else begin
          list_vals[list_len] = r.value;
          e.position = list_len[5:0];
          list_len++;
        end
      end
      uvlt_pkg::FUNC_DELETE: begin
        if (idx < list_len) begin
          for (int i = idx; i + 1 < list_len; i++)
            list_vals[i] = list_vals[i + 1];
          list_len--;
          e.position = idx[5:0];
        end else begin
          e.status = uvlt_pkg::ST_MISSING;
        end
      end
      default: ;
    endcase
    e.count = list_len[6:0];
    return e;
  endfunction

  // drive one request after a random gap (none when no_gaps is set) and wait until it is taken
  task automatic send_req(input logic [2:0] func, input logic [31:0] value);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    req.func = func;
    req.value = value;
    do begin
      @(posedge clk);
    end while (busy);
    pending_rsp.push_back(list_update(req));
  endtask

  // compare each result with the oldest owed one
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result status=%0d position=%0d count=%0d",
                 $time, rsp.status, rsp.position, rsp.count);
        errors++;
      end else begin
        owed = pending_rsp.pop_front();
        if (rsp.status !== owed.status) begin
          $display("%0t: status expected %0d actual %0d", $time, owed.status, rsp.status);
          errors++;
        end
        if (rsp.position !== owed.position) begin
          $display("%0t: position expected %0d actual %0d",
                   $time, owed.position, rsp.position);
          errors++;
        end
        if (rsp.count !== owed.count) begin
          $display("%0t: count expected %0d actual %0d", $time, owed.count, rsp.count);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // a random value, often drawn from the pool of recurring values
  function automatic logic [31:0] pick_value();
    if (value_pool.size() != 0 && $urandom_range(0, 99) < 80)
      return value_pool[$urandom_range(0, value_pool.size() - 1)];
    return $urandom;
  endfunction

  // requests on an empty list
  task automatic test_empty_list();
    send_req(uvlt_pkg::FUNC_COUNT, 32'h0);
    send_req(uvlt_pkg::FUNC_SEARCH, 32'h0);
    send_req(uvlt_pkg::FUNC_DELETE, 32'hFFFF_FFFF);
  endtask

  // extreme values, duplicates, deletes at head, middle and tail, unused codes, clear and count
  task automatic test_extreme_values();
    send_req(uvlt_pkg::FUNC_INSERT, 32'h8000_0000);
    send_req(uvlt_pkg::FUNC_INSERT, 32'h7FFF_FFFF);
    send_req(uvlt_pkg::FUNC_INSERT, 32'h0000_0000);
    send_req(uvlt_pkg::FUNC_INSERT, 32'hFFFF_FFFF);
    send_req(uvlt_pkg::FUNC_INSERT, 32'h0000_0001);
    send_req(uvlt_pkg::FUNC_INSERT, 32'h7FFF_FFFF);
    send_req(uvlt_pkg::FUNC_SEARCH, 32'hFFFF_FFFF);
    send_req(uvlt_pkg::FUNC_SEARCH, 32'h1234_5678);
    send_req(uvlt_pkg::FUNC_DELETE, 32'h7FFF_FFFF);
    send_req(uvlt_pkg::FUNC_DELETE, 32'h8000_0000);
    send_req(uvlt_pkg::FUNC_DELETE, 32'h0000_0001);
    send_req(uvlt_pkg::FUNC_SEARCH, 32'hFFFF_FFFF);
    for (int f = uvlt_pkg::FUNC_DELETE + 1; f <= FUNC_LAST; f++)
      send_req(f[2:0], 32'hA5A5_5A5A);
    send_req(uvlt_pkg::FUNC_CLEAR, 32'hFFFF_FFFF);
    send_req(uvlt_pkg::FUNC_COUNT, 32'h0);
  endtask

  // fill the store to capacity, push past it, then delete everything
  task automatic test_fill_drain(input int rounds);
    int pick;
    for (int r = 0; r < rounds; r++) begin
      no_gaps = (r == 1);
      while (list_len < CAPACITY) begin
        if ($urandom_range(0, 7) == 0 && list_len > 0)
          send_req(uvlt_pkg::FUNC_SEARCH, list_vals[$urandom_range(0, list_len - 1)]);
        else
          send_req(uvlt_pkg::FUNC_INSERT, $urandom);
      end
      // full store: new values refused, held values reported as present
      repeat (4) send_req(uvlt_pkg::FUNC_INSERT, $urandom);
      repeat (3)
        send_req(uvlt_pkg::FUNC_INSERT, list_vals[$urandom_range(0, list_len - 1)]);
      send_req(uvlt_pkg::FUNC_INSERT, list_vals[CAPACITY - 1]);
      send_req(uvlt_pkg::FUNC_COUNT, $urandom);
      // drain in random order
      while (list_len > 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0)
          send_req(uvlt_pkg::FUNC_DELETE, $urandom);
        else if (pick == 1)
          send_req(uvlt_pkg::FUNC_SEARCH, list_vals[$urandom_range(0, list_len - 1)]);
        else
          send_req(uvlt_pkg::FUNC_DELETE, list_vals[$urandom_range(0, list_len - 1)]);
      end
    end
    no_gaps = 1'b0;
  endtask

  // mixed requests over a shifting pool of recurring values
  task automatic test_random_mix(input int phases, input int per_phase);
    int          w;
    int          pool_size;
    logic [31:0] v;
    for (int p = 0; p < phases; p++) begin
      value_pool.delete();
      pool_size = $urandom_range(8, 90);
      repeat (pool_size) value_pool.push_back($urandom);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (per_phase) begin
        w = $urandom_range(0, 99);
        v = pick_value();
        if (w < 46) begin
          send_req(uvlt_pkg::FUNC_INSERT, v);
        end else if (w < 71) begin
          if (list_len > 0 && $urandom_range(0, 1) == 0)
            v = list_vals[$urandom_range(0, list_len - 1)];
          send_req(uvlt_pkg::FUNC_DELETE, v);
        end else if (w < 89) begin
          send_req(uvlt_pkg::FUNC_SEARCH, v);
        end else if (w < 94) begin
          send_req(uvlt_pkg::FUNC_COUNT, v);
        end else if (w < 95) begin
          send_req(uvlt_pkg::FUNC_CLEAR, v);
        end else begin
          send_req(3'($urandom_range(uvlt_pkg::FUNC_DELETE + 1, FUNC_LAST)), v);
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  // test sequence
  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    errors = 0;
    list_len = 0;
    no_gaps = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_list();
    test_extreme_values();
    test_fill_drain(3);
    test_random_mix(7, 150);

    @(negedge clk);
    start = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### unique_value_list_table_unit.f
rtl/uvlt_pkg.sv
rtl/uvlt_ctrl.sv
rtl/uvlt_datapath.sv
rtl/unique_value_list_table_unit.sv
test/tb_unique_value_list_table_unit.sv
